/* rtl/core/durs_pkg.sv */
package durs_pkg;

  // Default width of the per-sensor echo counters
  localparam int unsigned DIST_BITS_DEF = 8;

  // Field widths
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SCALE_W = 4;
  localparam int unsigned DIST_W  = 12;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // Register reset values
  localparam logic [TICK_W-1:0]  REPLY_TIMEOUT_RST = 16'd18;
  localparam logic [TICK_W-1:0]  SETTLE_LIMIT_RST  = 16'd103;
  localparam logic [SCALE_W-1:0] UNIT_SCALE_RST    = 4'd5;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REPLY_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_SCALE    = 2'd2;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_TRIG_R   = 4'd1,
    PH_WAIT_R   = 4'd2,
    PH_READ_R   = 4'd3,
    PH_SETTLE_R = 4'd4,
    PH_TRIG_L   = 4'd5,
    PH_WAIT_L   = 4'd6,
    PH_READ_L   = 4'd7,
    PH_SETTLE_L = 4'd8
  } durs_phase_t;

  // One result transaction
  typedef struct packed {
    logic              trig_right;
    logic              trig_left;
    logic              ready;
    logic [DIST_W-1:0] distance;
  } durs_res_t;

endpackage

/* rtl/core/durs_seq.sv */
module durs_seq #(
  parameter int unsigned DistBits = durs_pkg::DIST_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic                            kind,
  input  logic                            echo_right,
  input  logic                            echo_left,
  input  logic [durs_pkg::TICK_W-1:0]     reply_timeout,
  input  logic [durs_pkg::TICK_W-1:0]     settle_limit,
  input  logic [durs_pkg::SCALE_W-1:0]    unit_scale,
  output durs_pkg::durs_res_t             res
);
  import durs_pkg::*;

  localparam int unsigned ProdW = DistBits + SCALE_W;
  localparam int unsigned CmpW  = (ProdW > DIST_W) ? ProdW : DIST_W;
  localparam logic [DistBits-1:0] DistMax = '1;
  localparam logic [TICK_W-1:0]   TickMax = '1;
  localparam logic [DIST_W-1:0]   OutMax  = '1;

  durs_phase_t         phase_r, phase_nxt;
  logic [TICK_W-1:0]   tick_count_r, tick_count_nxt;
  logic [DistBits-1:0] dist_right_r, dist_right_nxt;
  logic [DistBits-1:0] dist_left_r, dist_left_nxt;

  logic [TICK_W-1:0]   tick_inc;
  logic [DistBits-1:0] dist_min;
  logic [ProdW-1:0]    prod;
  logic [CmpW-1:0]     prod_ext;
  logic                trig_right;
  logic                trig_left;

  // Saturating tick counter increment
  assign tick_inc = (tick_count_r != TickMax) ? tick_count_r + 1'b1 : tick_count_r;

  // Next state and strobes for one transaction
  always_comb begin
    phase_nxt      = phase_r;
    tick_count_nxt = tick_count_r;
    dist_right_nxt = dist_right_r;
    dist_left_nxt  = dist_left_r;
    trig_right     = 1'b0;
    trig_left      = 1'b0;
    if (kind) begin
      phase_nxt = PH_TRIG_R;
    end else begin
      unique case (phase_r)
        PH_TRIG_R: begin
          trig_right     = 1'b1;
          tick_count_nxt = '0;
          phase_nxt      = PH_WAIT_R;
        end
        PH_WAIT_R: begin
          tick_count_nxt = tick_inc;
          if (echo_right) begin
            phase_nxt      = PH_READ_R;
            dist_right_nxt = '0;
          end
          // timeout takes priority over a coincident echo rise
          if (tick_inc > reply_timeout) begin
            phase_nxt      = PH_SETTLE_R;
            dist_right_nxt = '0;
          end
        end
        PH_READ_R: begin
          tick_count_nxt = tick_inc;
          if (dist_right_r != DistMax) dist_right_nxt = dist_right_r + 1'b1;
          if (!echo_right) phase_nxt = PH_SETTLE_R;
        end
        PH_SETTLE_R: begin
          tick_count_nxt = tick_inc;
          if (tick_inc > settle_limit) phase_nxt = PH_TRIG_L;
        end
        PH_TRIG_L: begin
          trig_left      = 1'b1;
          tick_count_nxt = '0;
          phase_nxt      = PH_WAIT_L;
        end
        PH_WAIT_L: begin
          tick_count_nxt = tick_inc;
          if (echo_left) begin
            phase_nxt     = PH_READ_L;
            dist_left_nxt = '0;
          end
          if (tick_inc > reply_timeout) begin
            phase_nxt     = PH_SETTLE_L;
            dist_left_nxt = '0;
          end
        end
        PH_READ_L: begin
          tick_count_nxt = tick_inc;
          if (dist_left_r != DistMax) dist_left_nxt = dist_left_r + 1'b1;
          if (!echo_left) phase_nxt = PH_SETTLE_L;
        end
        PH_SETTLE_L: begin
          tick_count_nxt = tick_inc;
          if (tick_inc > settle_limit) phase_nxt = PH_IDLE;
        end
        default: begin
        end
      endcase
    end
  end

  // Result fields from the updated state
  assign dist_min  = (dist_right_nxt < dist_left_nxt) ? dist_right_nxt : dist_left_nxt;
  assign prod      = ProdW'(dist_min) * ProdW'(unit_scale);
  assign prod_ext  = CmpW'(prod);
  assign res.trig_right = trig_right;
  assign res.trig_left  = trig_left;
  assign res.ready = (phase_nxt == PH_IDLE) || (phase_nxt == PH_SETTLE_L);
  assign res.distance = (prod_ext > CmpW'(OutMax)) ? OutMax : prod_ext[DIST_W-1:0];

  // State registers, updated once per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_count_r <= '0;
      dist_right_r <= '0;
      dist_left_r  <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      tick_count_r <= tick_count_nxt;
      dist_right_r <= dist_right_nxt;
      dist_left_r  <= dist_left_nxt;
    end
  end

endmodule

/* rtl/core/dual_ultrasonic_ranger_sequencer.sv */
// An accepted transaction's result is captured straight into the single output register.
// Throughput: one transaction per cycle while out_ready drains a waiting result; the
// state update and min-times-scale product sit between input handshake and result register.
// Reset (synchronous, rst_n low): phase idle, counters and distances zero, registers back
// to 18 / 103 / 5, output register empty.
module dual_ultrasonic_ranger_sequencer #(
  parameter int unsigned DIST_BITS = durs_pkg::DIST_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic                              in_echo_right,
  input  logic                              in_echo_left,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_trigger_right,
  output logic                              out_trigger_left,
  output logic                              out_ready_res,
  output logic [durs_pkg::DIST_W-1:0]       out_distance_cm,
  // configuration port
  input  logic                              cfg_we,
  input  logic [durs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [durs_pkg::CFG_W-1:0]        cfg_wdata
);
  import durs_pkg::*;

  logic [TICK_W-1:0]  reply_timeout_r;
  logic [TICK_W-1:0]  settle_limit_r;
  logic [SCALE_W-1:0] unit_scale_r;

  logic      accept;
  logic      out_valid_r, out_valid_nxt;
  durs_res_t res_nxt;
  durs_res_t res_r;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reply_timeout_r <= REPLY_TIMEOUT_RST;
      settle_limit_r  <= SETTLE_LIMIT_RST;
      unit_scale_r    <= UNIT_SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPLY_TIMEOUT: reply_timeout_r <= cfg_wdata;
        REG_SETTLE_LIMIT:  settle_limit_r  <= cfg_wdata;
        REG_UNIT_SCALE:    unit_scale_r    <= cfg_wdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Take a new transaction whenever the result register is free or draining
  assign in_ready      = !out_valid_r || out_ready;
  assign accept        = in_valid && in_ready;
  assign out_valid_nxt = accept || (out_valid_r && !out_ready);

  durs_seq #(
    .DistBits (DIST_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (accept),
    .kind          (in_kind),
    .echo_right    (in_echo_right),
    .echo_left     (in_echo_left),
    .reply_timeout (reply_timeout_r),
    .settle_limit  (settle_limit_r),
    .unit_scale    (unit_scale_r),
    .res           (res_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_trigger_right = res_r.trig_right;
  assign out_trigger_left  = res_r.trig_left;
  assign out_ready_res     = res_r.ready;
  assign out_distance_cm   = res_r.distance;

endmodule

/* tb/ranger_result_checker.sv */
module ranger_result_checker #(
  parameter int unsigned DIST_BITS = durs_pkg::DIST_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_kind,
  input  logic                           in_echo_right,
  input  logic                           in_echo_left,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_trigger_right,
  input  logic                           out_trigger_left,
  input  logic                           out_ready_res,
  input  logic [durs_pkg::DIST_W-1:0]    out_distance_cm,
  input  logic                           cfg_we,
  input  logic [durs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [durs_pkg::CFG_W-1:0]     cfg_wdata,
  output int                             n_pending,
  output int                             n_errors
);
  import durs_pkg::*;

  localparam logic [DIST_BITS-1:0] DIST_TOP  = '1;
  localparam logic [TICK_W-1:0]    TICK_TOP  = '1;
  localparam int unsigned          DIST_CLIP = 4095;

  // Local copy of the registers
  logic [TICK_W-1:0]    timeout_ticks;
  logic [TICK_W-1:0]    settle_ticks;
  logic [SCALE_W-1:0]   cm_per_tick;

  // Local copy of the sequencer state
  durs_phase_t          seq_phase;
  logic [TICK_W-1:0]    ticks;
  logic [DIST_BITS-1:0] range_r;
  logic [DIST_BITS-1:0] range_l;

  // Readings still owed by the block, oldest first
  durs_res_t            reading_q[$];

  function automatic void tick_up();
    if (ticks != TICK_TOP) ticks = ticks + 1'b1;
  endfunction

  // Advance the sequencer by one transaction and work out the reading it gives
  function automatic durs_res_t next_reading(input logic kind, input logic er, input logic el);
    durs_res_t            res;
    logic [DIST_BITS-1:0] nearer;
    int unsigned          cm;
    res = '0;
    if (kind) begin
      // a start restarts the cycle from any phase, no strobe yet
      seq_phase = PH_TRIG_R;
    end else begin
      case (seq_phase)
        PH_TRIG_R: begin
          res.trig_right = 1'b1;
          ticks = '0;
          seq_phase = PH_WAIT_R;
        end
        PH_WAIT_R: begin
          tick_up();
          if (er) begin
            seq_phase = PH_READ_R;
            range_r = '0;
          end
          // timeout overrides an echo rising on the same tick
          if (ticks > timeout_ticks) begin
            seq_phase = PH_SETTLE_R;
            range_r = '0;
          end
        end
        PH_READ_R: begin
          tick_up();
          if (range_r != DIST_TOP) range_r = range_r + 1'b1;
          if (!er) seq_phase = PH_SETTLE_R;
        end
        PH_SETTLE_R: begin
          tick_up();
          if (ticks > settle_ticks) seq_phase = PH_TRIG_L;
        end
        PH_TRIG_L: begin
          res.trig_left = 1'b1;
          ticks = '0;
          seq_phase = PH_WAIT_L;
        end
        PH_WAIT_L: begin
          tick_up();
          if (el) begin
            seq_phase = PH_READ_L;
            range_l = '0;
          end
          if (ticks > timeout_ticks) begin
            seq_phase = PH_SETTLE_L;
            range_l = '0;
          end
        end
        PH_READ_L: begin
          tick_up();
          if (range_l != DIST_TOP) range_l = range_l + 1'b1;
          if (!el) seq_phase = PH_SETTLE_L;
        end
        PH_SETTLE_L: begin
          tick_up();
          if (ticks > settle_ticks) seq_phase = PH_IDLE;
        end
        default: ;
      endcase
    end
    nearer = (range_r < range_l) ? range_r : range_l;
    cm = nearer * cm_per_tick;
    if (cm > DIST_CLIP) cm = DIST_CLIP;
    res.distance = cm[DIST_W-1:0];
    res.ready = (seq_phase == PH_IDLE) || (seq_phase == PH_SETTLE_L);
    return res;
  endfunction

  always @(posedge clk) begin
    durs_res_t want;
    if (!rst_n) begin
      timeout_ticks = REPLY_TIMEOUT_RST;
      settle_ticks  = SETTLE_LIMIT_RST;
      cm_per_tick   = UNIT_SCALE_RST;
      seq_phase     = PH_IDLE;
      ticks         = '0;
      range_r       = '0;
      range_l       = '0;
      reading_q.delete();
    end else begin
      // Compare a delivered reading against the oldest one owed
      if (out_valid && out_ready) begin
        if (reading_q.size() == 0) begin
          $error("result transaction with no expectation waiting");
          n_errors++;
        end else begin
          want = reading_q.pop_front();
          if (out_trigger_right !== want.trig_right) begin
            $error("trigger_right: expected %0d, got %0d", want.trig_right, out_trigger_right);
            n_errors++;
          end
          if (out_trigger_left !== want.trig_left) begin
            $error("trigger_left: expected %0d, got %0d", want.trig_left, out_trigger_left);
            n_errors++;
          end
          if (out_ready_res !== want.ready) begin
            $error("ready_res: expected %0d, got %0d", want.ready, out_ready_res);
            n_errors++;
          end
          if (out_distance_cm !== want.distance) begin
            $error("distance_cm: expected %0d, got %0d", want.distance, out_distance_cm);
            n_errors++;
          end
        end
      end

      // Register writes; unknown indexes are dropped
      if (cfg_we) begin
        case (cfg_index)
          REG_REPLY_TIMEOUT: timeout_ticks = cfg_wdata;
          REG_SETTLE_LIMIT:  settle_ticks  = cfg_wdata;
          REG_UNIT_SCALE:    cm_per_tick   = cfg_wdata[SCALE_W-1:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        reading_q.push_back(next_reading(in_kind, in_echo_right, in_echo_left));
      end
    end
    n_pending <= reading_q.size();
  end

endmodule

/* tb/testbench.sv */
module testbench;
  import durs_pkg::*;

  localparam int unsigned              HOLD_CYCLES = 300;
  localparam int unsigned              SAT_TICKS   = 100;
  localparam longint unsigned          RUN_LIMIT   = 64'd30_000_000;
  localparam logic [CFG_IDX_W-1:0]     REG_SPARE   = 2'd3;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_kind = 1'b0;
  logic                 in_echo_right = 1'b0;
  logic                 in_echo_left = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_trigger_right;
  logic                 out_trigger_left;
  logic                 out_ready_res;
  logic [DIST_W-1:0]    out_distance_cm;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  int                   n_pending;
  int                   n_errors;

  // Traffic shaping controls
  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_req = 1'b0;
  int cur_reply = REPLY_TIMEOUT_RST;
  int cur_settle = SETTLE_LIMIT_RST;

  // Echo waveforms: alternating runs of random length
  logic lvl_r = 1'b0;
  logic lvl_l = 1'b0;
  int   run_r = 0;
  int   run_l = 0;

  dual_ultrasonic_ranger_sequencer DUT (.*);

  ranger_result_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic int echo_run(input logic high);
    if (!high) return $urandom_range(1, 30);
    if ($urandom_range(0, 9) == 0) return $urandom_range(13, 40);
    return $urandom_range(1, 12);
  endfunction

  task automatic step_echo_waves(output logic er, output logic el);
    if (run_r == 0) begin
      lvl_r = ~lvl_r;
      run_r = echo_run(lvl_r);
    end
    if (run_l == 0) begin
      lvl_l = ~lvl_l;
      run_l = echo_run(lvl_l);
    end
    run_r--;
    run_l--;
    er = lvl_r;
    el = lvl_l;
  endtask

  // Offer one transaction and return at the edge that accepts it
  task automatic send_item(input logic kind, input logic er, input logic el);
    int gap;
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_echo_right <= er;
    in_echo_left  <= el;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Wait until every owed reading has been delivered
  task automatic drain();
    do @(negedge clk); while (n_pending != 0);
    @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    drain();
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(input logic [TICK_W-1:0] to, input logic [TICK_W-1:0] sl,
                            input logic [SCALE_W-1:0] sc, input bit spare);
    cfg_we    <= 1'b1;
    cfg_index <= REG_REPLY_TIMEOUT;
    cfg_wdata <= to;
    @(posedge clk);
    cfg_index <= REG_SETTLE_LIMIT;
    cfg_wdata <= sl;
    @(posedge clk);
    // junk in the upper bits must be dropped
    cfg_index <= REG_UNIT_SCALE;
    cfg_wdata <= {(CFG_W-SCALE_W)'($urandom), sc};
    @(posedge clk);
    if (spare) begin
      cfg_index <= REG_SPARE;
      cfg_wdata <= CFG_W'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur_reply  = to;
    cur_settle = sl;
  endtask

  // Measurement cycles with random echoes; starts mostly after a full cycle
  task automatic random_traffic(input int n_items, input bit do_hold);
    int   since_start;
    int   start_at;
    int   span;
    logic er;
    logic el;
    span = (cur_reply > cur_settle) ? cur_reply : cur_settle;
    if (span > 200) span = 200;
    span = 2 * (span + 16);
    since_start = 0;
    start_at = 0;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 3) begin
        in_valid <= 1'b0;
        drain();
      end
      if (do_hold && i == n_items / 2) hold_req = 1'b1;
      if (since_start >= start_at) begin
        send_item(1'b1, 1'($urandom), 1'($urandom));
        since_start = 0;
        start_at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, span)
                                               : span + $urandom_range(0, 20);
      end else begin
        step_echo_waves(er, el);
        send_item(1'b0, er, el);
        since_start++;
      end
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic er;
    logic el;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values
    random_traffic(100, 1'b0);

    // Directed: short limits, full scale
    quiesce();
    write_regs(16'd3, 16'd6, 4'd15, 1'b1);
    send_item(1'b0, 1'b1, 1'b1);          // tick before the start
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b0, 1'b0, 1'b0);          // right trigger
    repeat (3) send_item(1'b0, 1'b1, 1'b0);
    send_item(1'b0, 1'b0, 1'b0);          // echo ends, right settle
    repeat (3) send_item(1'b0, 1'b0, 1'b1);
    send_item(1'b0, 1'b1, 1'b0);          // left trigger
    repeat (3) send_item(1'b0, 1'b0, 1'b0);
    send_item(1'b0, 1'b1, 1'b1);          // echo rises on the timeout tick
    repeat (3) send_item(1'b0, 1'b0, 1'b0);
    send_item(1'b1, 1'b1, 1'b1);
    send_item(1'b0, 1'b1, 1'b1);
    send_item(1'b1, 1'b0, 1'b0);          // restart mid cycle
    send_item(1'b0, 1'b1, 1'b1);
    send_item(1'b0, 1'b1, 1'b1);

    // Zero limits and zero scale
    quiesce();
    write_regs(16'd0, 16'd0, 4'd0, 1'b0);
    random_traffic(120, 1'b0);

    // Timeout never passed: only an echo leaves the wait
    quiesce();
    write_regs(16'hFFFF, 16'd12, 4'd15, 1'b0);
    random_traffic(150, 1'b0);

    // Settle never passed: right settle holds until a restart
    quiesce();
    write_regs(16'd1, 16'hFFFF, 4'd1, 1'b0);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_item(1'b1, 1'b0, 1'b0);
    repeat (SAT_TICKS) begin
      step_echo_waves(er, el);
      send_item(1'b0, er, el);
    end
    send_item(1'b1, 1'b0, 1'b0);
    repeat (4) send_item(1'b0, 1'b0, 1'b0);

    // Long echoes on both sides saturate the distance counters
    quiesce();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    write_regs(16'd2000, 16'd30, 4'd15, 1'b0);
    send_item(1'b1, 1'b0, 1'b0);
    send_item(1'b0, 1'b0, 1'b0);
    repeat (280) send_item(1'b0, 1'b1, 1'b0);
    repeat (3) send_item(1'b0, 1'b0, 1'b0);
    repeat (280) send_item(1'b0, 1'b0, 1'b1);
    repeat (5) send_item(1'b0, 1'b0, 1'b0);

    // Random settings
    for (int k = 0; k < 4; k++) begin
      quiesce();
      tx_gaps = (k == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_gaps = (k == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
      write_regs(TICK_W'($urandom_range(1, 40)), TICK_W'($urandom_range(1, 90)),
                 SCALE_W'($urandom_range(0, 15)), 1'b0);
      random_traffic(150, k == 1);
    end

    in_valid <= 1'b0;
    drain();
    repeat (8) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
